FILE: hw/rtl/mcc_pkg.sv
// Package: shared types and constants for the current-compensation calibrator.
`timescale 1ns / 1ps
`default_nettype none
package mcc_pkg;
  localparam int Samples = 50;
  localparam logic [15:0] SpanReset = 16'd6554;
  localparam int QueueDepth = 2;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_LOW   = 2'd1,
    CMD_HIGH  = 2'd2,
    CMD_APPLY = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PH_LOW    = 2'd0,
    PH_HIGH   = 2'd1,
    PH_DONE   = 2'd2,
    PH_FAILED = 2'd3
  } phase_t;

  // One classified item passed from the front to the back.
  typedef struct packed {
    cmd_t               command;
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_z;
    logic [15:0]        throttle;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_ROUND,
    ST_OUT
  } back_state_t;
endpackage
`default_nettype wire

FILE: hw/rtl/mcc_front.sv
// Front: accepts input beats into a short queue toward the back end.
`timescale 1ns / 1ps
`default_nettype none
module mcc_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire mcc_pkg::item_t  in_item,
  output logic                 q_valid,
  input  wire logic            q_ready,
  output mcc_pkg::item_t       q_item
);
  mcc_pkg::item_t entry [mcc_pkg::QueueDepth];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready = (count != 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_item = entry[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= in_item;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/mcc_divider.sv
// Restoring divider: 64-bit dividend by 23-bit divisor, one quotient bit a cycle.
`timescale 1ns / 1ps
`default_nettype none
module mcc_divider (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [22:0] divisor,
  output logic             done,
  output logic [63:0]      quotient
);
  logic [23:0] rem;
  logic [63:0] quo;
  logic [6:0]  bits_left;
  logic        busy;
  logic [23:0] trial;
  logic [24:0] diff;

  assign trial = {rem[22:0], quo[63]};
  assign diff = {1'b0, trial} - {2'b0, divisor};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      bits_left <= 7'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        bits_left <= 7'd64;
      end else if (busy) begin
        bits_left <= bits_left - 7'd1;
        if (bits_left == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
    if (start) begin
      rem <= 24'd0;
      quo <= dividend;
    end else if (busy) begin
      if (!diff[24]) begin
        rem <= diff[23:0];
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[62:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/mcc_back.sv
// Back: updates sums, computes coefficients with the divider, applies compensation.
`timescale 1ns / 1ps
`default_nettype none
module mcc_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [15:0]    min_throttle_span,
  input  wire logic           q_valid,
  output logic                q_ready,
  input  wire mcc_pkg::item_t q_item,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [56:0]         out_data
);
  mcc_pkg::back_state_t state, state_next;
  mcc_pkg::item_t cur;
  logic signed [21:0] lsum [3];
  logic signed [21:0] hsum [3];
  logic [21:0] lthr, hthr;
  logic [5:0]  lcnt, hcnt;
  logic signed [39:0] coeff [3];
  logic cal, failed;
  logic [1:0] axis;
  logic signed [16:0] res [3];
  logic signed [56:0] prod;
  logic        div_start, div_done;
  logic [63:0] div_q;
  logic signed [22:0] sdiff;
  logic [22:0] mag_d;
  logic signed [22:0] dthr;
  logic [22:0] need;
  logic [1:0] ph;
  logic [5:0] taken;
  logic signed [15:0] mag_cur;
  logic [56:0] pmag;
  logic signed [25:0] corr;
  logic signed [26:0] o;
  logic seq_busy;
  logic fin_ok;
  logic fin_now;
  logic div_kick;

  assign dthr = $signed({1'b0, hthr}) - $signed({1'b0, lthr});
  assign need = 23'(min_throttle_span) * 23'(mcc_pkg::Samples);
  assign sdiff = 23'(hsum[axis]) - 23'(lsum[axis]);
  assign mag_d = sdiff[22] ? 23'(-sdiff) : sdiff;
  assign mag_cur = (axis == 2'd0) ? cur.mag_x : (axis == 2'd1) ? cur.mag_y : cur.mag_z;
  assign q_ready = (state == mcc_pkg::ST_IDLE);

  mcc_divider u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend({9'd0, mag_d, 32'd0}), .divisor(dthr),
    .done(div_done), .quotient(div_q)
  );

  assign fin_ok = !(dthr <= 0) && !($unsigned(dthr) < need);
  assign fin_now = (cur.command == mcc_pkg::CMD_HIGH) && (hcnt == 6'(mcc_pkg::Samples))
                   && !cal && !failed;

  always_comb begin
    state_next = state;
    case (state)
      mcc_pkg::ST_IDLE: if (q_valid) state_next = mcc_pkg::ST_DIV;
      mcc_pkg::ST_DIV: begin
        if (!seq_busy) begin
          if (!(fin_now && fin_ok)) state_next = mcc_pkg::ST_MUL;
        end else if (div_done && axis == 2'd2) begin
          state_next = mcc_pkg::ST_MUL;
        end
      end
      mcc_pkg::ST_MUL: state_next = mcc_pkg::ST_ROUND;
      mcc_pkg::ST_ROUND: state_next = (axis == 2'd2) ? mcc_pkg::ST_OUT : mcc_pkg::ST_MUL;
      mcc_pkg::ST_OUT: if (out_ready) state_next = mcc_pkg::ST_IDLE;
      default: state_next = mcc_pkg::ST_IDLE;
    endcase
  end

  // Absolute value of the product, rounded half away from zero.
  assign pmag = prod[56] ? 57'(-prod) : 57'(prod);
  assign corr = prod[56] ? -$signed({1'b0, 25'((pmag + 57'h80000000) >> 32)})
                         :  $signed({1'b0, 25'((pmag + 57'h80000000) >> 32)});
  assign o = 27'(mag_cur) - 27'(corr);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mcc_pkg::ST_IDLE;
      for (int i = 0; i < 3; i++) begin
        lsum[i] <= '0; hsum[i] <= '0; coeff[i] <= '0;
      end
      lthr <= '0; hthr <= '0; lcnt <= '0; hcnt <= '0;
      cal <= 1'b0; failed <= 1'b0; seq_busy <= 1'b0;
      axis <= 2'd0;
    end else begin
      state <= state_next;
      case (state)
        mcc_pkg::ST_IDLE: if (q_valid) begin
          cur <= q_item;
          axis <= 2'd0;
          seq_busy <= 1'b0;
          case (q_item.command)
            mcc_pkg::CMD_START: begin
              for (int i = 0; i < 3; i++) begin
                lsum[i] <= '0; hsum[i] <= '0;
              end
              lthr <= '0; hthr <= '0; lcnt <= '0; hcnt <= '0;
              cal <= 1'b0; failed <= 1'b0;
            end
            mcc_pkg::CMD_LOW: if (lcnt < 6'(mcc_pkg::Samples)) begin
              lsum[0] <= lsum[0] + 22'(q_item.mag_x);
              lsum[1] <= lsum[1] + 22'(q_item.mag_y);
              lsum[2] <= lsum[2] + 22'(q_item.mag_z);
              lthr <= lthr + 22'(q_item.throttle);
              lcnt <= lcnt + 6'd1;
            end
            mcc_pkg::CMD_HIGH:
              if (lcnt >= 6'(mcc_pkg::Samples) && hcnt < 6'(mcc_pkg::Samples)) begin
                hsum[0] <= hsum[0] + 22'(q_item.mag_x);
                hsum[1] <= hsum[1] + 22'(q_item.mag_y);
                hsum[2] <= hsum[2] + 22'(q_item.mag_z);
                hthr <= hthr + 22'(q_item.throttle);
                hcnt <= hcnt + 6'd1;
              end
            default: ;
          endcase
        end
        mcc_pkg::ST_DIV: begin
          // Finish check runs once, with the updated sums.
          if (!seq_busy) begin
            if (fin_now) begin
              if (fin_ok) seq_busy <= 1'b1;
              else failed <= 1'b1;
            end
          end else if (div_done) begin
            if (sdiff[22])
              coeff[axis] <= (div_q > 64'd549755813888) ? {1'b1, 39'd0} : 40'(-div_q);
            else
              coeff[axis] <= (div_q > 64'd549755813887) ? {1'b0, {39{1'b1}}} : 40'(div_q);
            if (axis == 2'd2) begin
              axis <= 2'd0;
              cal <= 1'b1;
            end else begin
              axis <= axis + 2'd1;
            end
          end
        end
        mcc_pkg::ST_MUL: prod <= $signed({1'b0, cur.throttle}) * coeff[axis];
        mcc_pkg::ST_ROUND: begin
          if (!cal) res[axis] <= 17'(mag_cur);
          else if (o > 27'sd32767) res[axis] <= 17'sd32767;
          else if (o < -27'sd32768) res[axis] <= -17'sd32768;
          else res[axis] <= 17'(o);
          if (axis != 2'd2) axis <= axis + 2'd1;
        end
        default: ;
      endcase
    end
  end

  // Kick the divider per axis while the coefficient sequence runs.
  always_ff @(posedge clk) begin
    if (rst) div_kick <= 1'b0;
    else div_kick <= (state == mcc_pkg::ST_DIV) &&
                     ((!seq_busy && fin_now && fin_ok) ||
                      (seq_busy && div_done && axis != 2'd2));
  end
  assign div_start = div_kick;

  always_comb begin
    if (lcnt < 6'(mcc_pkg::Samples)) begin
      ph = mcc_pkg::PH_LOW; taken = lcnt;
    end else if (hcnt < 6'(mcc_pkg::Samples)) begin
      ph = mcc_pkg::PH_HIGH; taken = hcnt;
    end else begin
      ph = failed ? mcc_pkg::PH_FAILED : mcc_pkg::PH_DONE; taken = hcnt;
    end
  end

  assign out_valid = (state == mcc_pkg::ST_OUT);
  assign out_data = {taken, ph, cal,
                     res[2][15:0], res[1][15:0], res[0][15:0]};
endmodule
`default_nettype wire

FILE: hw/rtl/mag_current_comp_calibrator.sv
// Path: an input beat passes the two-entry queue, then the back end states DIV,
// MUL and ROUND per axis, and OUT; the item that completes calibration adds three
// serial 64-step divisions in DIV. The back end takes a new item only from IDLE;
// the two-entry queue keeps accepting beats while the back end works, until full.
// Reset (rst, synchronous): clears sums, counts, coefficients, flags, queue;
// min_throttle_span returns to 6554.
`timescale 1ns / 1ps
`default_nettype none
module mag_current_comp_calibrator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // command[1:0], mag_x[17:2], mag_y[33:18], mag_z[49:34], throttle[65:50], zero pad
  input  wire logic [71:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // out_mag_x[15:0], out_mag_y[31:16], out_mag_z[47:32], is_calibrated[48],
  // phase[50:49], samples_taken[56:51], zero pad
  output logic [63:0]      m_axis_tdata
);
  logic [15:0] span;
  mcc_pkg::item_t in_item, q_item;
  logic q_valid, q_ready;
  logic [56:0] od;

  always_ff @(posedge clk) begin
    if (rst) span <= mcc_pkg::SpanReset;
    else if (cfg_we) span <= cfg_wdata;
  end

  assign in_item.command  = mcc_pkg::cmd_t'(s_axis_tdata[1:0]);
  assign in_item.mag_x    = s_axis_tdata[17:2];
  assign in_item.mag_y    = s_axis_tdata[33:18];
  assign in_item.mag_z    = s_axis_tdata[49:34];
  assign in_item.throttle = s_axis_tdata[65:50];

  mcc_front u_front (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  mcc_back u_back (
    .clk(clk), .rst(rst), .min_throttle_span(span), .q_valid(q_valid),
    .q_ready(q_ready), .q_item(q_item), .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready), .out_data(od)
  );

  assign m_axis_tdata = {7'd0, od};

  a_out_no_drop: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");
  a_queue_hold: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> q_valid)
    else $error("queue full but back end sees nothing");
endmodule
`default_nettype wire

FILE: tb/tb.sv
// Testbench for the magnetometer current-compensation calibrator.
`timescale 1ns / 1ps
module tb;
  import mcc_pkg::*;

  localparam int LimitCycles = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;

  mag_current_comp_calibrator u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Calibrator state mirror
  logic [15:0] span_min;
  logic signed [21:0] lo_sx, lo_sy, lo_sz, hi_sx, hi_sy, hi_sz;
  logic [21:0] lo_st, hi_st;
  int lo_n, hi_n;
  logic signed [39:0] k_x, k_y, k_z;
  bit cal_ok, cal_bad;

  logic [63:0] comp_q[$];
  int errors = 0;
  longint cycles = 0;
  bit drain_done = 1'b0;

  function automatic logic signed [39:0] coeff_of(logic signed [21:0] hs,
                                                  logic signed [21:0] ls,
                                                  longint dthr);
    longint d;
    longint unsigned m, q;
    d = longint'(hs) - longint'(ls);
    m = (d < 0) ? -d : d;
    q = (m << 32) / longint'(dthr);
    if (d < 0) begin
      if (q > 64'd549755813888) return -40'sd549755813888;
      return 40'(-longint'(q));
    end
    if (q > 64'd549755813887) return 40'sd549755813887;
    return 40'(q);
  endfunction

  function automatic logic [15:0] corrected(logic signed [15:0] m, logic [15:0] thr,
                                           logic signed [39:0] k);
    longint p, c, o;
    longint unsigned a;
    if (!cal_ok) return m;
    p = longint'({1'b0, thr}) * longint'(k);
    a = (p < 0) ? -p : p;
    c = (a + 64'h8000_0000) >> 32;
    if (p < 0) c = -c;
    o = longint'(m) - c;
    if (o > 32767) o = 32767;
    if (o < -32768) o = -32768;
    return o[15:0];
  endfunction

  function automatic void clear_sums();
    lo_sx = '0; lo_sy = '0; lo_sz = '0; hi_sx = '0; hi_sy = '0; hi_sz = '0;
    lo_st = '0; hi_st = '0; lo_n = 0; hi_n = 0; cal_ok = 1'b0; cal_bad = 1'b0;
  endfunction

  function automatic logic [63:0] predict_comp(cmd_t cmd, logic signed [15:0] mx,
      logic signed [15:0] my, logic signed [15:0] mz, logic [15:0] thr);
    longint dthr;
    phase_t ph;
    logic [5:0] taken;
    case (cmd)
      CMD_START: clear_sums();
      CMD_LOW: if (lo_n < Samples) begin
        lo_sx += 22'(mx); lo_sy += 22'(my); lo_sz += 22'(mz); lo_st += 22'(thr); lo_n++;
      end
      CMD_HIGH: if (lo_n >= Samples && hi_n < Samples) begin
        hi_sx += 22'(mx); hi_sy += 22'(my); hi_sz += 22'(mz); hi_st += 22'(thr); hi_n++;
        if (hi_n >= Samples) begin
          dthr = longint'(hi_st) - longint'(lo_st);
          if (dthr <= 0 || dthr < longint'(span_min) * Samples) cal_bad = 1'b1;
          else begin
            k_x = coeff_of(hi_sx, lo_sx, dthr);
            k_y = coeff_of(hi_sy, lo_sy, dthr);
            k_z = coeff_of(hi_sz, lo_sz, dthr);
            cal_ok = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (lo_n < Samples) begin
      ph = PH_LOW; taken = 6'(lo_n);
    end else if (hi_n < Samples) begin
      ph = PH_HIGH; taken = 6'(hi_n);
    end else begin
      ph = cal_bad ? PH_FAILED : PH_DONE; taken = 6'(hi_n);
    end
    return {7'd0, taken, ph, cal_ok, corrected(mz, thr, k_z),
            corrected(my, thr, k_y), corrected(mx, thr, k_x)};
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Send one beat, then predict it.
  task automatic send_beat(cmd_t cmd, logic signed [15:0] mx, logic signed [15:0] my,
                           logic signed [15:0] mz, logic [15:0] thr, bit quiet = 1'b0);
    int g;
    g = quiet ? 0 : gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, thr, mz, my, mx, cmd};
    do @(posedge clk); while (!s_axis_tready);
    comp_q.push_back(predict_comp(cmd, mx, my, mz, thr));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (comp_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_span(logic [15:0] v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    span_min = v;
  endtask

  function automatic logic [15:0] rnd16();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  // Run one calibration: start, low set, high set, then random low, high or apply beats.
  task automatic run_calibration(logic [15:0] thr_lo, logic [15:0] thr_hi, int spread,
                                 int extra);
    int i;
    logic signed [15:0] bx, by, bz;
    bx = 16'($urandom()); by = 16'($urandom()); bz = 16'($urandom());
    send_beat(CMD_START, 16'($urandom()), 16'($urandom()), 16'($urandom()),
              16'($urandom()));
    for (i = 0; i < Samples; i++)
      send_beat(CMD_LOW, 16'((bx >>> 2) + $urandom_range(0, spread)),
                16'((by >>> 2) - $urandom_range(0, spread)), 16'($urandom()),
                16'(thr_lo + $urandom_range(0, 50)));
    for (i = 0; i < Samples; i++)
      send_beat(CMD_HIGH, bx, by, 16'((bz >>> 1) + $urandom_range(0, spread)),
                16'(thr_hi - $urandom_range(0, 50)));
    for (i = 0; i < extra; i++)
      send_beat(cmd_t'($urandom_range(1, 3)), rnd16(), rnd16(), rnd16(), rnd16());
  endtask

  task automatic test_directed();
    send_beat(CMD_APPLY, 16'sh7fff, -16'sh8000, 16'sh0, 16'hffff);
    send_beat(CMD_HIGH, 16'sh1234, 16'sh0, 16'shffff, 16'h0);
    send_beat(CMD_LOW, -16'sh8000, 16'sh7fff, 16'sh7fff, 16'hffff);
    send_beat(CMD_LOW, 16'sh7fff, -16'sh8000, -16'sh8000, 16'h0);
    send_beat(CMD_START, 16'shaaaa, 16'sh5555, 16'sh0f0f, 16'hffff);
    send_beat(CMD_APPLY, -16'sh1, 16'sh1, 16'sh0, 16'h0001);
  endtask

  // Full-scale low and high sets give large coefficients that saturate the outputs.
  task automatic test_extremes();
    int i;
    send_beat(CMD_START, 16'sh0, 16'sh0, 16'sh0, 16'h0);
    for (i = 0; i < Samples; i++)
      send_beat(CMD_LOW, -16'sh8000, 16'sh7fff, 16'sh0, 16'h0, 1'b1);
    for (i = 0; i < Samples + 2; i++)
      send_beat(CMD_HIGH, 16'sh7fff, -16'sh8000, 16'sh0, 16'hffff, 1'b1);
    send_beat(CMD_LOW, 16'sh0, 16'sh0, 16'sh0, 16'h0);
    send_beat(CMD_APPLY, -16'sh8000, 16'sh7fff, 16'sh1, 16'hffff);
    send_beat(CMD_APPLY, 16'sh7fff, -16'sh8000, 16'sh1, 16'h8000);
  endtask

  task automatic test_span_fail();
    run_calibration(16'h4000, 16'h4100, 30, 4);  // span too small
    run_calibration(16'h8000, 16'h1000, 30, 3);  // negative span
  endtask

  task automatic test_random(int cals, int beats);
    int i;
    for (i = 0; i < cals; i++) run_calibration(16'($urandom_range(0, 20000)),
                                               16'($urandom_range(40000, 65000)),
                                               $urandom_range(0, 3000), 10);
    for (i = 0; i < beats; i++)
      send_beat(cmd_t'($urandom_range(0, 3)), rnd16(), rnd16(), rnd16(), rnd16());
  endtask

  // Result checker
  always @(posedge clk) begin
    logic [63:0] exp_d;
    cycles <= cycles + 1;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (comp_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat %h", m_axis_tdata);
      end else begin
        exp_d = comp_q.pop_front();
        if (exp_d[56:0] != m_axis_tdata[56:0]) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp x=%h y=%h z=%h cal=%b ph=%0d n=%0d",
                     exp_d[15:0], exp_d[31:16], exp_d[47:32], exp_d[48],
                     exp_d[50:49], exp_d[56:51],
                     "  got x=%h y=%h z=%h cal=%b ph=%0d n=%0d",
                     m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
                     m_axis_tdata[48], m_axis_tdata[50:49], m_axis_tdata[56:51]);
        end
      end
    end
  end

  // Output stall pattern, with stretches of steady ready
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (drain_done || (cycles / 2000) % 3 == 0) m_axis_tready <= 1'b1;
    else if (r < 55) m_axis_tready <= 1'b1;
    else if (r < 97) m_axis_tready <= 1'b0;
    else m_axis_tready <= ~m_axis_tready;
  end

  always @(posedge clk) begin
    if (cycles > LimitCycles) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    span_min = SpanReset;
    k_x = '0; k_y = '0; k_z = '0;
    clear_sums();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_extremes();
    write_span(16'hffff);
    test_span_fail();
    write_span(16'h0000);
    test_random(1, 20);
    write_span(16'd1000);
    test_random(0, 30);
    write_span(16'd12000);
    test_random(0, 30);
    drain_done = 1'b1;
    wait_idle();
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule

FILE: mag_current_comp_calibrator.f
hw/rtl/mcc_pkg.sv
hw/rtl/mcc_front.sv
hw/rtl/mcc_divider.sv
hw/rtl/mcc_back.sv
hw/rtl/mag_current_comp_calibrator.sv
tb/tb.sv
